/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer package
// Field widths, character codes, register map, item types and sequencer
// states shared by the text console writer files.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned PosW  = 11;
  localparam int unsigned CharW = 8;
  localparam int unsigned AttrW = 8;
  localparam int unsigned IdxW  = 11;
  localparam int unsigned CellW = AttrW + CharW;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CharW-1:0] CodeBackspace = 8'd8;
  localparam logic [CharW-1:0] CodeLinefeed  = 8'd10;
  localparam logic [CharW-1:0] CodeReturn    = 8'd13;

  localparam logic ModePut  = 1'b0;
  localparam logic ModeRead = 1'b1;

  localparam logic [AddrW-1:0] RegAttrAddr = 3'd0;
  localparam logic [AttrW-1:0] AttrReset   = 8'd7;

  typedef struct packed {
    logic             mode;
    logic [CharW-1:0] char_code;
    logic [IdxW-1:0]  cell_index;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0]  cursor_position;
    logic [CharW-1:0] cell_char;
    logic [AttrW-1:0] cell_attr;
    logic             scrolled;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

/* design/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cell store and cursor
// Takes put and read items, keeps a ROWS x COLUMNS cell memory and a cursor,
// and scrolls the screen up one row when the cursor leaves the last row.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o carry one in_t item; mode 0 puts
//   char_code at the cursor (backspace, linefeed and return handled), mode 1
//   reads cell cell_index
//   output channel: out_valid_o / out_ready_i carry one out_t item per input
//   item, in order
//   apb port: register 0 is the attribute byte, reset 7
// sequence
//   put without scroll: idle state, then done state
//   read: idle, read and done states (registered read of the cell memory)
//   scroll: idle, copy and done states; the row copy moves one cell per cycle
//   through the single read and write port pair
// reset
//   the cursor goes to cell 0 and a clearing pass writes zero to every cell;
//   in_ready_o stays low until it ends
// stall
//   a finished result waits in the output register; the next item is still
//   taken and its work runs until its own result needs that register
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tcw_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tcw_pkg::out_t             out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tcw_pkg::AddrW-1:0] paddr,
  input  logic [tcw_pkg::DataW-1:0] pwdata,
  output logic [tcw_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned CellCount    = COLUMNS * ROWS;
  localparam int unsigned LastRowStart = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW           = $clog2(CellCount);
  localparam int unsigned CntW         = $clog2(CellCount + 1);
  localparam int unsigned ColW         = $clog2(COLUMNS);

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0]             cursor_q, cursor_d;
  logic [ColW-1:0]           col_q, col_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [CntW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]             wr_ptr_q, wr_ptr_d;
  logic                      pend_q, pend_d;
  logic [tcw_pkg::AttrW-1:0] attr_q;
  tcw_pkg::out_t             res_q, res_d;
  tcw_pkg::out_t             out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [tcw_pkg::CellW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [tcw_pkg::CellW-1:0] ram_rdata;

  logic [31:0]               idx_wide;
  logic [AW-1:0]             idx_addr;
  logic                      idx_in_range;
  logic                      cfg_write;

  function automatic logic [tcw_pkg::PosW-1:0] to_pos(input logic [AW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[tcw_pkg::PosW-1:0];
  endfunction

  assign idx_wide     = 32'(in_data_i.cell_index);
  assign idx_addr     = idx_wide[AW-1:0];
  assign idx_in_range = idx_wide < CellCount;

  // apb register
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == tcw_pkg::RegAttrAddr) ?
                     tcw_pkg::DataW'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::AttrReset;
    end else if (cfg_write && paddr == tcw_pkg::RegAttrAddr) begin
      attr_q <= pwdata[tcw_pkg::AttrW-1:0];
    end
  end

  assign in_ready_o  = (state_q == tcw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic scroll;
    scroll      = 1'b0;
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    clr_d       = clr_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cursor_q;
    ram_wdata   = {attr_q, in_data_i.char_code};
    ram_re      = 1'b0;
    ram_raddr   = idx_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(CellCount - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = tcw_pkg::ST_DONE;
          if (in_data_i.mode == tcw_pkg::ModeRead) begin
            if (idx_in_range) begin
              ram_re  = 1'b1;
              state_d = tcw_pkg::ST_READ;
            end
          end else if (in_data_i.char_code == tcw_pkg::CodeBackspace) begin
            if (cursor_q != '0) begin
              cursor_d  = cursor_q - AW'(1);
              col_d     = (col_q == '0) ? ColW'(COLUMNS - 1) : col_q - ColW'(1);
              ram_we    = 1'b1;
              ram_waddr = cursor_q - AW'(1);
              ram_wdata = {attr_q, {tcw_pkg::CharW{1'b0}}};
            end
          end else if (in_data_i.char_code == tcw_pkg::CodeLinefeed ||
                       in_data_i.char_code == tcw_pkg::CodeReturn) begin
            if (cursor_q >= AW'(LastRowStart)) begin
              scroll = 1'b1;
            end else begin
              cursor_d = cursor_q - AW'(col_q) + AW'(COLUMNS);
              col_d    = '0;
            end
          end else begin
            ram_we = 1'b1;
            if (cursor_q == AW'(CellCount - 1)) begin
              scroll = 1'b1;
            end else begin
              cursor_d = cursor_q + AW'(1);
              col_d    = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + ColW'(1);
            end
          end
          if (scroll) begin
            cursor_d       = AW'(LastRowStart);
            col_d          = '0;
            rd_ptr_d       = CntW'(COLUMNS);
            wr_ptr_d       = '0;
            res_d.scrolled = 1'b1;
            state_d        = tcw_pkg::ST_COPY;
          end
          res_d.cursor_position = to_pos(cursor_d);
        end
      end
      tcw_pkg::ST_READ: begin
        res_d.cell_char = ram_rdata[tcw_pkg::CharW-1:0];
        res_d.cell_attr = ram_rdata[tcw_pkg::CellW-1:tcw_pkg::CharW];
        state_d         = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_COPY: begin
        // row copy: read cell n+COLUMNS, write it to cell n in the following cycle
        ram_raddr = rd_ptr_q[AW-1:0];
        if (rd_ptr_q < CntW'(CellCount)) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CntW'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_q;
          ram_wdata = ram_rdata;
          wr_ptr_d  = wr_ptr_q + AW'(1);
          if (wr_ptr_q == AW'(LastRowStart - 1)) begin
            state_d = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      cursor_q    <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      clr_q       <= clr_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  tcw_ram #(
    .Width (tcw_pkg::CellW),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* design/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker: port checks for the text console writer
// Watches the item channels and the apb port of the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input tcw_pkg::out_t out_data_o,
  input logic          pready
);

  localparam int unsigned CellCount    = COLUMNS * ROWS;
  localparam int unsigned LastRowStart = (ROWS - 1) * COLUMNS;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |->
      out_data_o.cursor_position == tcw_pkg::PosW'(LastRowStart))
    else $error("scroll left cursor off the last row start");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.cursor_position) < CellCount)
    else $error("cursor beyond the screen");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("apb pready low");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

/* dv/text_console_writer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker: scoreboard for the text console writer
// Watches the item channels and the apb port, keeps its own copy of the cell
// store, cursor and attribute, predicts one result per taken item and
// compares each returned result field by field against the oldest one.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  tcw_pkg::in_t              in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  tcw_pkg::out_t             out_data_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [tcw_pkg::AddrW-1:0] paddr_i,
  input  logic [tcw_pkg::DataW-1:0] pwdata_i,
  input  logic [tcw_pkg::DataW-1:0] prdata_i,
  input  logic                      pready_i,
  output int                        errors_o,
  output int                        pending_o
);

  localparam int unsigned CellCount    = COLUMNS * ROWS;
  localparam int unsigned LastRowStart = (ROWS - 1) * COLUMNS;

  logic [tcw_pkg::CellW-1:0] cell_mem [CellCount];
  logic [tcw_pkg::PosW-1:0]  cur_cell;
  logic [tcw_pkg::AttrW-1:0] attr_byte;
  tcw_pkg::out_t             expected_q [$];
  tcw_pkg::out_t             oldest;

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (errors_o < 10) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, exp_val, act_val);
    end
    errors_o++;
  endtask

  function automatic void scroll_rows();
    for (int i = 0; i < LastRowStart; i++) begin
      cell_mem[i] = cell_mem[i + COLUMNS];
    end
    cur_cell = tcw_pkg::PosW'(LastRowStart);
  endfunction

  function automatic tcw_pkg::out_t predict_console(tcw_pkg::in_t item);
    tcw_pkg::out_t res;
    int unsigned   row;
    res = '0;
    if (item.mode == tcw_pkg::ModeRead) begin
      if (item.cell_index < CellCount) begin
        res.cell_char = cell_mem[item.cell_index][tcw_pkg::CharW-1:0];
        res.cell_attr = cell_mem[item.cell_index][tcw_pkg::CellW-1:tcw_pkg::CharW];
      end
    end else if (item.char_code == tcw_pkg::CodeBackspace) begin
      if (cur_cell != 0) begin
        cur_cell = cur_cell - 1'b1;
        cell_mem[cur_cell] = {attr_byte, {tcw_pkg::CharW{1'b0}}};
      end
    end else if (item.char_code == tcw_pkg::CodeLinefeed ||
                 item.char_code == tcw_pkg::CodeReturn) begin
      row = cur_cell / COLUMNS;
      if (row + 1 >= ROWS) begin
        scroll_rows();
        res.scrolled = 1'b1;
      end else begin
        cur_cell = tcw_pkg::PosW'((row + 1) * COLUMNS);
      end
    end else begin
      cell_mem[cur_cell] = {attr_byte, item.char_code};
      if (cur_cell + 1 >= CellCount) begin
        scroll_rows();
        res.scrolled = 1'b1;
      end else begin
        cur_cell = cur_cell + 1'b1;
      end
    end
    res.cursor_position = cur_cell;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CellCount; i++) begin
        cell_mem[i] = '0;
      end
      cur_cell  = '0;
      attr_byte = tcw_pkg::AttrReset;
      expected_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", '0, 32'(out_data_i));
        end else begin
          oldest = expected_q.pop_front();
          if (out_data_i.cursor_position !== oldest.cursor_position) begin
            report_mismatch("cursor_position", 32'(oldest.cursor_position),
                            32'(out_data_i.cursor_position));
          end
          if (out_data_i.cell_char !== oldest.cell_char) begin
            report_mismatch("cell_char", 32'(oldest.cell_char), 32'(out_data_i.cell_char));
          end
          if (out_data_i.cell_attr !== oldest.cell_attr) begin
            report_mismatch("cell_attr", 32'(oldest.cell_attr), 32'(out_data_i.cell_attr));
          end
          if (out_data_i.scrolled !== oldest.scrolled) begin
            report_mismatch("scrolled", 32'(oldest.scrolled), 32'(out_data_i.scrolled));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_console(in_data_i));
      end
      if (psel_i && penable_i && pready_i && paddr_i == tcw_pkg::RegAttrAddr) begin
        if (pwrite_i) begin
          attr_byte = pwdata_i[tcw_pkg::AttrW-1:0];
        end else if (prdata_i[tcw_pkg::AttrW-1:0] !== attr_byte) begin
          report_mismatch("char_attribute", 32'(attr_byte),
                          32'(prdata_i[tcw_pkg::AttrW-1:0]));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* dv/text_console_writer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test: testbench top for the text console writer
// Drives put and read items and attribute writes with random idle bursts on
// both channels, starting with edge cases (reads past the screen, backspace
// at cell zero, new line and character on the last row) and then random
// phases under changing attributes; the checker does the comparing.
// ----------------------------------------------------------------------------
module text_console_writer_test;

  localparam int unsigned Columns     = 80;
  localparam int unsigned Rows        = 25;
  localparam int unsigned CellCount   = Columns * Rows;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 12_000_000;

  localparam logic [tcw_pkg::AddrW-1:0] UnusedRegAddr = 3'd4;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  tcw_pkg::in_t              in_data;
  logic                      out_valid;
  logic                      out_ready;
  tcw_pkg::out_t             out_data;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [tcw_pkg::AddrW-1:0] paddr;
  logic [tcw_pkg::DataW-1:0] pwdata;
  logic [tcw_pkg::DataW-1:0] prdata;
  logic                      pready;

  int               fail_cnt;
  int               pending_cnt;
  logic             in_taken;
  bit               quiet;
  int unsigned      cycle_cnt = 0;

  text_console_writer #(
    .COLUMNS (Columns),
    .ROWS    (Rows)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  text_console_writer_checker #(
    .COLUMNS (Columns),
    .ROWS    (Rows)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .errors_o    (fail_cnt),
    .pending_o   (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("text_console_writer_test: errors");
    $finish;
  end

  // receiver stalls
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < 12) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic tcw_pkg::in_t make_item(logic mode, logic [tcw_pkg::CharW-1:0] code,
                                             logic [tcw_pkg::IdxW-1:0] idx);
    tcw_pkg::in_t item;
    item.mode       = mode;
    item.char_code  = code;
    item.cell_index = idx;
    return item;
  endfunction

  function automatic tcw_pkg::in_t random_item();
    int unsigned              pick;
    logic [tcw_pkg::IdxW-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = tcw_pkg::IdxW'($urandom_range(CellCount, 2047));
      end else begin
        idx = tcw_pkg::IdxW'($urandom_range(0, CellCount - 1));
      end
      return make_item(tcw_pkg::ModeRead, tcw_pkg::CharW'($urandom()), idx);
    end else if (pick < 36) begin
      return make_item(tcw_pkg::ModePut, tcw_pkg::CodeBackspace, tcw_pkg::IdxW'($urandom()));
    end else if (pick < 42) begin
      return make_item(tcw_pkg::ModePut,
                       $urandom_range(0, 1) ? tcw_pkg::CodeLinefeed : tcw_pkg::CodeReturn,
                       tcw_pkg::IdxW'($urandom()));
    end
    return make_item(tcw_pkg::ModePut, tcw_pkg::CharW'($urandom()),
                     tcw_pkg::IdxW'($urandom()));
  endfunction

  // leaves valid high after the handshake so the next item can follow at once
  task automatic send_item(tcw_pkg::in_t item);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic put_code(logic [tcw_pkg::CharW-1:0] code);
    send_item(make_item(tcw_pkg::ModePut, code, tcw_pkg::IdxW'($urandom())));
  endtask

  task automatic read_cell(logic [tcw_pkg::IdxW-1:0] idx);
    send_item(make_item(tcw_pkg::ModeRead, tcw_pkg::CharW'($urandom()), idx));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic apb_access(logic write, logic [tcw_pkg::AddrW-1:0] addr,
                            logic [tcw_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_attr(logic [tcw_pkg::AttrW-1:0] attr);
    apb_access(1'b1, tcw_pkg::RegAttrAddr,
               {(tcw_pkg::DataW - tcw_pkg::AttrW)'($urandom()), attr});
    apb_access(1'b0, tcw_pkg::RegAttrAddr, '0);
  endtask

  initial begin
    logic [tcw_pkg::AttrW-1:0] attr;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    rst_n    = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apb_access(1'b0, tcw_pkg::RegAttrAddr, '0);

    // edges of the screen and cursor at cell zero
    read_cell('0);
    read_cell(tcw_pkg::IdxW'(CellCount - 1));
    read_cell(tcw_pkg::IdxW'(CellCount));
    read_cell(11'h7ff);
    put_code(tcw_pkg::CodeBackspace);
    put_code(8'h00);
    put_code(8'hff);
    put_code(8'h41);
    put_code(tcw_pkg::CodeBackspace);
    read_cell(tcw_pkg::IdxW'(2));
    read_cell(tcw_pkg::IdxW'(1));
    put_code(tcw_pkg::CodeLinefeed);
    put_code(tcw_pkg::CodeReturn);

    drain_results();
    set_attr(8'hff);
    put_code(8'h55);
    read_cell(tcw_pkg::IdxW'(2 * Columns));

    drain_results();
    set_attr(8'h00);
    apb_access(1'b1, UnusedRegAddr, '1);
    put_code(8'haa);
    put_code(tcw_pkg::CodeBackspace);
    read_cell(tcw_pkg::IdxW'(2 * Columns + 1));

    drain_results();
    set_attr(8'h5a);
    // walk down to the last row, then new line and character on the last row
    repeat (Rows - 3) put_code(tcw_pkg::CodeLinefeed);
    put_code(tcw_pkg::CodeLinefeed);
    read_cell(tcw_pkg::IdxW'((Rows - 2) * Columns));
    repeat (Columns) put_code(tcw_pkg::CharW'($urandom_range(32, 126)));
    read_cell(tcw_pkg::IdxW'(CellCount - 1));
    read_cell(tcw_pkg::IdxW'((Rows - 1) * Columns - 1));

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      case (p)
        0:       attr = 8'hff;
        1:       attr = 8'h00;
        2:       attr = 8'h01;
        3:       attr = 8'h80;
        default: attr = tcw_pkg::AttrW'($urandom());
      endcase
      set_attr(attr);
      if (p == PhaseCount - 1) begin
        quiet = 1'b1;
      end
      repeat (RandomItems / PhaseCount) send_item(random_item());
    end

    drain_results();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("text_console_writer_test: clean");
    end else begin
      $display("text_console_writer_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer.sv
design/tcw_checker.sv
dv/text_console_writer_checker.sv
dv/text_console_writer_test.sv
